// ===== rtl/core/sequence_valve_timer_core_defines.svh =====
// Assertion macros shared by the valve timer RTL.
`ifndef SEQUENCE_VALVE_TIMER_CORE_DEFINES_SVH
`define SEQUENCE_VALVE_TIMER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define SVT_ASSERT_IMP(name, clk_i, rstn_i, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
    else $error("valve timer check failed: same-cycle implication");
// Next-cycle implication, checked out of reset.
`define SVT_ASSERT_NXT(name, clk_i, rstn_i, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
    else $error("valve timer check failed: next-cycle implication");
`else
`define SVT_ASSERT_IMP(name, clk_i, rstn_i, ante, cons)
`define SVT_ASSERT_NXT(name, clk_i, rstn_i, ante, cons)
`endif

`endif

// ===== rtl/core/svt_pkg.sv =====
package svt_pkg;

  localparam int NUM_VALVES_DEF = 3;
  // Valves that own a field in the configuration registers.
  localparam int FIELD_VALVES   = 3;
  localparam int MODE_W         = 3;
  localparam int FIELD_W        = 16;
  localparam int CFG_W          = 48;
  localparam int CFG_IDX_W      = 3;
  localparam int USE_MODES_W    = 9;
  localparam int OP_W           = 2;
  localparam int POS_W          = 16;
  localparam int OUT_BITS       = 3;
  localparam int CNT_W          = 2;
  // Sum of the active flags; the width holds up to seven.
  localparam int CNT_SUM_W      = 3;
  localparam int OUT_DATA_W     = 8;
  localparam int OUT_PAD_W      = OUT_DATA_W - OUT_BITS - CNT_W;

  typedef enum logic [OP_W-1:0] {
    OP_TICK = 2'd0,
    OP_ARM  = 2'd1,
    OP_STOP = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_USE_MODES   = 3'd0,
    CFG_OPEN_DELAYS = 3'd1,
    CFG_ON_TIMES    = 3'd2,
    CFG_START_POS   = 3'd3,
    CFG_END_POS     = 3'd4
  } cfg_idx_t;

  localparam logic [MODE_W-1:0] MODE_UNUSED    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TIME_TIME = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POS_POS   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TIME_POS  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_POS_TIME  = 3'd4;

  typedef enum logic [5:0] {
    PH_IDLE       = 6'b000001,
    PH_ARMED      = 6'b000010,
    PH_TIME_OPEN  = 6'b000100,
    PH_POS_OPEN   = 6'b001000,
    PH_TIME_CLOSE = 6'b010000,
    PH_POS_CLOSE  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [USE_MODES_W-1:0] use_modes;
    logic [CFG_W-1:0]       open_delays;
    logic [CFG_W-1:0]       on_times;
    logic [CFG_W-1:0]       start_positions;
    logic [CFG_W-1:0]       end_positions;
  } cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [FIELD_W-1:0] open_delay;
    logic [FIELD_W-1:0] on_time;
    logic [FIELD_W-1:0] start_pos;
    logic [FIELD_W-1:0] end_pos;
  } valve_cfg_t;

  typedef struct packed {
    logic             fire;
    op_t              op;
    logic [POS_W-1:0] pos;
  } step_t;

  typedef struct packed {
    logic on_nxt;
    logic act_r;
    logic act_nxt;
  } valve_stat_t;

endpackage

// ===== rtl/core/svt_cfg_regs.sv =====
module svt_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [svt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [svt_pkg::CFG_W-1:0]        cfg_data,
  output svt_pkg::cfg_t                    cfg
);
  import svt_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_USE_MODES:   cfg_r.use_modes       <= cfg_data[USE_MODES_W-1:0];
        CFG_OPEN_DELAYS: cfg_r.open_delays     <= cfg_data;
        CFG_ON_TIMES:    cfg_r.on_times        <= cfg_data;
        CFG_START_POS:   cfg_r.start_positions <= cfg_data;
        CFG_END_POS:     cfg_r.end_positions   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/svt_valve_cell.sv =====
module svt_valve_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  svt_pkg::step_t        step,
  input  svt_pkg::valve_cfg_t   vcfg,
  output svt_pkg::valve_stat_t  stat
);
  import svt_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [FIELD_W-1:0] ticks_r, ticks_nxt, ticks_inc;
  logic               on_r, on_nxt;
  phase_t             close_phase;

  always_comb begin
    ticks_inc   = (ticks_r == '1) ? ticks_r : ticks_r + FIELD_W'(1);
    close_phase = (vcfg.mode inside {MODE_TIME_TIME, MODE_POS_TIME}) ? PH_TIME_CLOSE
                                                                     : PH_POS_CLOSE;
  end

  always_comb begin
    phase_nxt = phase_r;
    ticks_nxt = ticks_r;
    on_nxt    = on_r;
    if (step.fire) begin
      case (step.op)
        OP_TICK: begin
          case (phase_r)
            PH_ARMED: begin
              ticks_nxt = '0;
              if (vcfg.mode inside {MODE_TIME_TIME, MODE_TIME_POS}) begin
                phase_nxt = PH_TIME_OPEN;
              end else if (vcfg.mode inside {MODE_POS_POS, MODE_POS_TIME}) begin
                phase_nxt = PH_POS_OPEN;
              end else begin
                phase_nxt = PH_IDLE;
              end
            end
            PH_TIME_OPEN: begin
              ticks_nxt = ticks_inc;
              if (ticks_inc > vcfg.open_delay) begin
                on_nxt    = 1'b1;
                ticks_nxt = '0;
                phase_nxt = close_phase;
              end
            end
            PH_POS_OPEN: begin
              if (step.pos <= vcfg.start_pos) begin
                on_nxt    = 1'b1;
                ticks_nxt = '0;
                phase_nxt = close_phase;
              end
            end
            PH_TIME_CLOSE: begin
              ticks_nxt = ticks_inc;
              if (ticks_inc > vcfg.on_time) begin
                on_nxt    = 1'b0;
                phase_nxt = PH_IDLE;
              end
            end
            PH_POS_CLOSE: begin
              if (step.pos <= vcfg.end_pos) begin
                on_nxt    = 1'b0;
                phase_nxt = PH_IDLE;
              end
            end
            default: ;
          endcase
        end
        // keep the drive bit; restart the sequence
        OP_ARM: begin
          phase_nxt = (vcfg.mode != MODE_UNUSED) ? PH_ARMED : PH_IDLE;
        end
        OP_STOP: begin
          on_nxt    = 1'b0;
          phase_nxt = PH_IDLE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      ticks_r <= '0;
      on_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      ticks_r <= ticks_nxt;
      on_r    <= on_nxt;
    end
  end

  assign stat.on_nxt  = on_nxt;
  assign stat.act_r   = (phase_r != PH_IDLE);
  assign stat.act_nxt = (phase_nxt != PH_IDLE);

endmodule

// ===== rtl/core/sequence_valve_timer_core.sv =====
// A beat accepted on the input is held in the input register, then its result in the result register.
// Throughput: one beat per cycle, in and out, while out_tready does not stall the result register;
// an input register and a result register split the two sides, and all valves update in parallel.
// Reset (rst_n low at a clock edge): all valves idle and off, tick counters and
// configuration registers zero, both stages empty.
`include "sequence_valve_timer_core_defines.svh"

module sequence_valve_timer_core #(
  parameter int NUM_VALVES = svt_pkg::NUM_VALVES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [svt_pkg::POS_W-1:0]          in_tdata,   // [15:0] position
  input  logic [svt_pkg::OP_W-1:0]           in_tuser,   // [1:0] op
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [svt_pkg::OUT_DATA_W-1:0]     out_tdata,  // [2:0] valve_outputs, [4:3] active_count
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [svt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [svt_pkg::CFG_W-1:0]          cfg_data
);
  import svt_pkg::*;

  logic                        s_v_r;
  op_t                         s_op_r;
  logic [POS_W-1:0]            s_pos_r;
  logic                        o_v_r;
  logic [OUT_BITS-1:0]         o_bits_r;
  logic [CNT_W-1:0]            o_cnt_r;
  logic                        adv;
  logic                        fire;
  cfg_t                        cfg;
  step_t                       step;
  valve_stat_t [NUM_VALVES-1:0] stats;
  logic [OUT_BITS-1:0]         bits_nxt;
  logic [CNT_SUM_W-1:0]        cnt_before;
  logic [CNT_SUM_W-1:0]        cnt_after;
  logic [CNT_W-1:0]            cnt_nxt;

  assign adv       = !o_v_r || out_tready;
  assign fire      = s_v_r && adv;
  assign in_tready = !s_v_r || adv;

  svt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign step.fire = fire;
  assign step.op   = s_op_r;
  assign step.pos  = s_pos_r;

  for (genvar v = 0; v < NUM_VALVES; v++) begin : g_valve
    valve_cfg_t vcfg;
    if (v < FIELD_VALVES) begin : g_field
      assign vcfg.mode       = cfg.use_modes[MODE_W*v +: MODE_W];
      assign vcfg.open_delay = cfg.open_delays[FIELD_W*v +: FIELD_W];
      assign vcfg.on_time    = cfg.on_times[FIELD_W*v +: FIELD_W];
      assign vcfg.start_pos  = cfg.start_positions[FIELD_W*v +: FIELD_W];
      assign vcfg.end_pos    = cfg.end_positions[FIELD_W*v +: FIELD_W];
    end else begin : g_nofield
      // no register field: reads as unused
      assign vcfg = '0;
    end

    svt_valve_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .step  (step),
      .vcfg  (vcfg),
      .stat  (stats[v])
    );
  end

  always_comb begin
    cnt_before = '0;
    cnt_after  = '0;
    bits_nxt   = '0;
    for (int v = 0; v < NUM_VALVES; v++) begin
      cnt_before = cnt_before + CNT_SUM_W'(stats[v].act_r);
      cnt_after  = cnt_after + CNT_SUM_W'(stats[v].act_nxt);
    end
    for (int b = 0; b < OUT_BITS && b < NUM_VALVES; b++) begin
      bits_nxt[b] = stats[b].on_nxt;
    end
    // tick reports the count at the start of the pass, the others after the beat
    cnt_nxt = (s_op_r == OP_TICK) ? cnt_before[CNT_W-1:0] : cnt_after[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s_v_r <= in_tvalid;
      end
      if (adv) begin
        o_v_r <= s_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s_op_r  <= op_t'(in_tuser);
      s_pos_r <= in_tdata;
    end
    if (fire) begin
      o_bits_r <= bits_nxt;
      o_cnt_r  <= cnt_nxt;
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, o_cnt_r, o_bits_r};

  `SVT_ASSERT_NXT(a_stop_clears, clk, rst_n, fire && s_op_r == OP_STOP, o_v_r && o_bits_r == '0 && o_cnt_r == '0)
  `SVT_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !o_v_r, in_tready)
  `SVT_ASSERT_NXT(a_no_phantom, clk, rst_n, !s_v_r && adv, !o_v_r)

endmodule

// ===== bench/sequence_valve_timer_checker.sv =====
`timescale 1ns / 100ps

module sequence_valve_timer_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [svt_pkg::POS_W-1:0]      in_tdata,   // [15:0] position
  input  logic [svt_pkg::OP_W-1:0]       in_tuser,   // [1:0] op
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [svt_pkg::OUT_DATA_W-1:0] out_tdata,  // [2:0] valve_outputs, [4:3] active_count
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [svt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [svt_pkg::CFG_W-1:0]      cfg_data,
  output int                             fail_count,
  output int                             pending_count
);
  import svt_pkg::*;

  localparam int NV = NUM_VALVES_DEF;

  // Highest field first: valve bits sit at [2:0].
  typedef struct packed {
    logic [CNT_W-1:0]    active;
    logic [OUT_BITS-1:0] valves;
  } valve_word_t;

  cfg_t               regs;
  phase_t             phase [NV];
  logic [FIELD_W-1:0] ticks [NV];
  logic               drive [NV];
  valve_word_t        valve_words_q [$];
  int                 result_beats;

  initial begin
    fail_count    = 0;
    pending_count = 0;
    result_beats  = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] result beat %0d: %s", $realtime, result_beats, msg);
    fail_count++;
  endtask

  function automatic logic [MODE_W-1:0] mode_of(input int v);
    if (v >= FIELD_VALVES) return MODE_UNUSED;
    return regs.use_modes[MODE_W*v +: MODE_W];
  endfunction

  function automatic logic [FIELD_W-1:0] field_of(input logic [CFG_W-1:0] r, input int v);
    if (v >= FIELD_VALVES) return '0;
    return r[FIELD_W*v +: FIELD_W];
  endfunction

  function automatic int count_active();
    int n;
    n = 0;
    for (int v = 0; v < NV; v++)
      if (phase[v] != PH_IDLE) n++;
    return n;
  endfunction

  task automatic bump_ticks(input int v);
    if (ticks[v] != '1) ticks[v] = ticks[v] + 1'b1;
  endtask

  task automatic open_valve(input int v);
    logic [MODE_W-1:0] m;
    m = mode_of(v);
    drive[v] = 1'b1;
    ticks[v] = '0;
    phase[v] = (m == MODE_TIME_TIME || m == MODE_POS_TIME) ? PH_TIME_CLOSE : PH_POS_CLOSE;
  endtask

  task automatic close_valve(input int v);
    drive[v] = 1'b0;
    phase[v] = PH_IDLE;
  endtask

  // Advance every valve by one input beat and form the result word.
  task automatic step_valves(input logic [OP_W-1:0] op_bits, input logic [POS_W-1:0] pos,
                             output valve_word_t res);
    int                  n;
    int                  v;
    logic [MODE_W-1:0]   m;
    logic [OUT_BITS-1:0] bits;
    bits = '0;
    if (op_bits == OP_TICK) begin
      // count is taken before the pass
      n = count_active();
      for (v = 0; v < NV; v++) begin
        m = mode_of(v);
        case (phase[v])
          PH_ARMED: begin
            ticks[v] = '0;
            if (m == MODE_TIME_TIME || m == MODE_TIME_POS) phase[v] = PH_TIME_OPEN;
            else if (m == MODE_POS_POS || m == MODE_POS_TIME) phase[v] = PH_POS_OPEN;
            else phase[v] = PH_IDLE;
          end
          PH_TIME_OPEN: begin
            bump_ticks(v);
            if (ticks[v] > field_of(regs.open_delays, v)) open_valve(v);
          end
          PH_POS_OPEN: begin
            if (pos <= field_of(regs.start_positions, v)) open_valve(v);
          end
          PH_TIME_CLOSE: begin
            bump_ticks(v);
            if (ticks[v] > field_of(regs.on_times, v)) close_valve(v);
          end
          PH_POS_CLOSE: begin
            if (pos <= field_of(regs.end_positions, v)) close_valve(v);
          end
          default: ;
        endcase
      end
    end else begin
      if (op_bits == OP_ARM) begin
        // drive bit and tick count are kept on re-arm
        for (v = 0; v < NV; v++) phase[v] = (mode_of(v) != MODE_UNUSED) ? PH_ARMED : PH_IDLE;
      end else if (op_bits == OP_STOP) begin
        for (v = 0; v < NV; v++) close_valve(v);
      end
      n = count_active();
    end
    for (v = 0; v < NV && v < OUT_BITS; v++) bits[v] = drive[v];
    res.valves = bits;
    res.active = n[CNT_W-1:0];
  endtask

  always @(posedge clk) begin
    valve_word_t want;
    valve_word_t got;
    if (!rst_n) begin
      regs = '0;
      for (int v = 0; v < NV; v++) begin
        phase[v] = PH_IDLE;
        ticks[v] = '0;
        drive[v] = 1'b0;
      end
      valve_words_q.delete();
    end else begin
      // compare first so a beat entering this edge is never matched against
      if (out_tvalid && out_tready) begin
        got = out_tdata[OUT_BITS+CNT_W-1:0];
        if (valve_words_q.size() == 0) begin
          report_mismatch($sformatf("no result pending, got data %0h", out_tdata));
        end else begin
          want = valve_words_q.pop_front();
          if (got.valves != want.valves)
            report_mismatch($sformatf("valve_outputs got %0h want %0h", got.valves, want.valves));
          if (got.active != want.active)
            report_mismatch($sformatf("active_count got %0d want %0d", got.active, want.active));
          if (out_tdata[OUT_DATA_W-1:OUT_BITS+CNT_W] != '0)
            report_mismatch($sformatf("padding bits not zero, data %0h", out_tdata));
        end
        result_beats++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_USE_MODES:   regs.use_modes       = cfg_data[USE_MODES_W-1:0];
          CFG_OPEN_DELAYS: regs.open_delays     = cfg_data;
          CFG_ON_TIMES:    regs.on_times        = cfg_data;
          CFG_START_POS:   regs.start_positions = cfg_data;
          CFG_END_POS:     regs.end_positions   = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        step_valves(in_tuser, in_tdata, want);
        valve_words_q.push_back(want);
      end
    end
    pending_count = valve_words_q.size();
  end

endmodule

// ===== bench/sequence_valve_timer_core_test.sv =====
`timescale 1ns / 100ps

module sequence_valve_timer_core_test;
  import svt_pkg::*;

  localparam int CYCLE_LIMIT = 50000;
  localparam int RAND_BEATS  = 1100;
  localparam int SAT_TICKS   = 40;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 200;
  localparam int QUIET_FROM  = 500;
  localparam int QUIET_TO    = 700;

  localparam logic [OP_W-1:0]      OP_UNDEFINED       = 2'd3;
  localparam logic [MODE_W-1:0]    MODE_IDLE_LO       = 3'd5;
  localparam logic [MODE_W-1:0]    MODE_IDLE_HI       = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_FIRST = 3'd5;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [POS_W-1:0]      in_tdata;   // [15:0] position
  logic [OP_W-1:0]       in_tuser;   // [1:0] op
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [2:0] valve_outputs, [4:3] active_count
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  int   fail_count;
  int   pending_count;
  int   cycle_count;
  int   beats_sent;
  int   hold_left;
  bit   hold_done;
  logic quiet_span;

  assign quiet_span = (beats_sent >= QUIET_FROM) && (beats_sent < QUIET_TO);

  sequence_valve_timer_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  sequence_valve_timer_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off while the sender keeps pushing.
  initial begin
    out_tready = 1'b0;
    hold_left  = 0;
    hold_done  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else if (!hold_done && beats_sent >= HOLD_AT) begin
        hold_done  = 1'b1;
        hold_left  = HOLD_CYCLES - 1;
        out_tready = 1'b0;
      end else begin
        out_tready = quiet_span ? 1'b1 : ($urandom_range(99) >= 6);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos);
    if (!quiet_span && $urandom_range(99) < 6) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(2, 1)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = pos;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Hold until every result is back, then let the pipeline empty.
  task automatic settle();
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [FIELD_W-1:0] pick_limit();
    int r;
    r = $urandom_range(19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return FIELD_W'($urandom());
    return FIELD_W'($urandom_range(12));
  endfunction

  initial begin
    logic [USE_MODES_W-1:0] modes;
    logic [CFG_W-1:0]       lims;
    logic [CFG_W-1:0]       lims2;
    logic [POS_W-1:0]       pos;
    int                     step;
    int                     n_ticks;
    int                     r;
    int                     rand_start;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = OP_TICK;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_USE_MODES;
    cfg_data   = '0;
    beats_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // All valves unused after reset.
    send_beat(OP_TICK, 16'h0000);
    send_beat(OP_ARM, 16'h0000);
    send_beat(OP_UNDEFINED, 16'hFFFF);

    // One valve each in time/time, pos/pos and time/pos style, re-arm while open, undefined op, stop.
    settle();
    cfg_write(CFG_USE_MODES, CFG_W'({MODE_TIME_POS, MODE_POS_POS, MODE_TIME_TIME}));
    cfg_write(CFG_OPEN_DELAYS, {16'd0, 16'd0, 16'd1});
    cfg_write(CFG_ON_TIMES, {16'd0, 16'd0, 16'd0});
    cfg_write(CFG_START_POS, {16'd0, 16'h8000, 16'd0});
    cfg_write(CFG_END_POS, {16'hFFFF, 16'h1000, 16'd0});
    send_beat(OP_ARM, 16'h0000);
    send_beat(OP_TICK, 16'hFFFF);
    send_beat(OP_TICK, 16'hFFFF);
    send_beat(OP_TICK, 16'h8000);
    send_beat(OP_TICK, 16'h0FFF);
    send_beat(OP_ARM, 16'h0000);
    send_beat(OP_TICK, 16'h0000);
    send_beat(OP_TICK, 16'h0000);
    send_beat(OP_UNDEFINED, 16'h0000);
    send_beat(OP_STOP, 16'h0000);
    send_beat(OP_TICK, 16'h0000);

    // Idle modes armed, open delays and start positions at all ones, writes to unmapped indexes.
    settle();
    cfg_write(CFG_USE_MODES, '1);
    for (int k = 0; k < 3; k++)
      cfg_write(CFG_IDX_W'(CFG_UNMAPPED_FIRST + k), CFG_W'({$urandom(), $urandom()}));
    cfg_write(CFG_OPEN_DELAYS, '1);
    cfg_write(CFG_ON_TIMES, '0);
    cfg_write(CFG_START_POS, '1);
    cfg_write(CFG_END_POS, '0);
    send_beat(OP_ARM, 16'h0000);
    send_beat(OP_TICK, 16'h1234);
    send_beat(OP_TICK, 16'h1234);

    settle();
    cfg_write(CFG_USE_MODES, CFG_W'({MODE_IDLE_HI, MODE_IDLE_LO, MODE_POS_TIME}));
    send_beat(OP_ARM, 16'h0000);
    send_beat(OP_TICK, 16'hFFFF);
    send_beat(OP_TICK, 16'h0000);
    send_beat(OP_TICK, 16'h0000);
    send_beat(OP_STOP, 16'h0000);

    // Random phases; registers change while valves may still be mid-sequence.
    rand_start = beats_sent;
    while (beats_sent < rand_start + RAND_BEATS) begin
      settle();
      if ($urandom_range(3) != 0) begin
        for (int v = 0; v < FIELD_VALVES; v++)
          modes[MODE_W*v +: MODE_W] = ($urandom_range(9) < 8) ? MODE_W'($urandom_range(4, 1))
                                                              : MODE_W'($urandom_range(7, 0));
        cfg_write(CFG_USE_MODES, CFG_W'(modes));
      end
      for (int v = 0; v < FIELD_VALVES; v++) begin
        lims[FIELD_W*v +: FIELD_W]  = pick_limit();
        lims2[FIELD_W*v +: FIELD_W] = pick_limit();
      end
      if ($urandom_range(3) != 0) cfg_write(CFG_OPEN_DELAYS, lims);
      if ($urandom_range(3) != 0) cfg_write(CFG_ON_TIMES, lims2);
      if ($urandom_range(3) != 0) cfg_write(CFG_START_POS, CFG_W'({$urandom(), $urandom()}));
      if ($urandom_range(3) != 0) cfg_write(CFG_END_POS, CFG_W'({$urandom(), $urandom()}));

      if ($urandom_range(9) < 8) begin
        // Arm, then a falling meter position with the odd stray op.
        send_beat(OP_ARM, POS_W'($urandom()));
        n_ticks = $urandom_range(40, 8);
        pos     = POS_W'($urandom());
        step    = $urandom_range(6000, 200);
        for (int t = 0; t < n_ticks; t++) begin
          r = $urandom_range(29);
          if (r == 0) send_beat(OP_ARM, POS_W'($urandom()));
          else if (r == 1) send_beat(OP_STOP, POS_W'($urandom()));
          else if (r == 2) send_beat(OP_UNDEFINED, POS_W'($urandom()));
          send_beat(OP_TICK, pos);
          pos = (pos > step) ? POS_W'(pos - step) : 16'h0000;
        end
        if ($urandom_range(1) == 0) send_beat(OP_STOP, POS_W'($urandom()));
      end else begin
        repeat ($urandom_range(20, 8))
          send_beat(OP_W'($urandom_range(3)), POS_W'($urandom()));
      end
    end

    // Limits at and next to the counter ceiling.
    settle();
    cfg_write(CFG_USE_MODES, CFG_W'({MODE_POS_TIME, MODE_TIME_TIME, MODE_TIME_TIME}));
    cfg_write(CFG_OPEN_DELAYS, {16'h0000, 16'hFFFE, 16'hFFFF});
    cfg_write(CFG_ON_TIMES, {16'hFFFF, 16'h0003, 16'h0000});
    cfg_write(CFG_START_POS, {16'hFFFF, 16'h0000, 16'h0000});
    cfg_write(CFG_END_POS, '0);
    send_beat(OP_ARM, 16'h0000);
    repeat (SAT_TICKS) send_beat(OP_TICK, POS_W'($urandom()));
    send_beat(OP_STOP, 16'h0000);
    send_beat(OP_TICK, 16'h0000);

    while (pending_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
